// File: hdl/jitl_pkg.sv
// Shared constants, types and helper functions for the joint impedance torque limiter.
// The interface, PD datapath, limiter and core files refer to this package by scoped names.
package jitl_pkg;

    // Number of joints that keep a previous command in the state memory.
    localparam int NUM_JOINTS = 7;
    localparam int MEM_AW     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Field widths of the input and result items.
    localparam int JOINT_W = 3;
    localparam int POS_W   = 20;
    localparam int VEL_W   = 18;
    localparam int KP_W    = 20;
    localparam int KD_W    = 16;
    localparam int FF_W    = 17;
    localparam int TQ_W    = 16;
    localparam int LIM_W   = 15;

    // Internal arithmetic widths.
    localparam int POS_SHIFT = 16;
    localparam int VEL_SHIFT = 12;
    localparam int DPOS_W    = POS_W + 1;
    localparam int DVEL_W    = VEL_W + 1;
    localparam int PPOS_W    = DPOS_W + KP_W + 1;
    localparam int PVEL_W    = DVEL_W + KD_W + 1;
    localparam int RAW_W     = 28;
    localparam int DIFF_W    = RAW_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WRIST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_WRIST  = 3'd5;

    // Reset values of the limit registers.
    localparam logic [LIM_W-1:0] RST_STEP_BASE  = 15'd1382;
    localparam logic [LIM_W-1:0] RST_STEP_MID   = 15'd845;
    localparam logic [LIM_W-1:0] RST_STEP_WRIST = 15'd243;
    localparam logic [LIM_W-1:0] RST_ABS_BASE   = 15'd27648;
    localparam logic [LIM_W-1:0] RST_ABS_MID    = 15'd16896;
    localparam logic [LIM_W-1:0] RST_ABS_WRIST  = 15'd4864;

    // Joint groups that share a pair of limits.
    typedef logic [1:0] t_grp;
    localparam t_grp GRP_BASE  = 2'd0;
    localparam t_grp GRP_MID   = 2'd1;
    localparam t_grp GRP_WRIST = 2'd2;
    localparam int   NUM_GRPS  = 3;

    typedef logic [JOINT_W-1:0] t_joint;

    // Item passed from the PD datapath to the limiter stage.
    typedef struct packed {
        t_joint                    joint;
        logic signed [RAW_W-1:0]   raw;
    } t_raw_item;

    // Result of the slew and magnitude limiter.
    typedef struct packed {
        logic signed [TQ_W-1:0] cmd;
        logic                   rate;
        logic                   mag;
    } t_lim_res;

    // Maps a joint index onto its limit group.
    function automatic t_grp jitl_group(input t_joint joint);
        t_grp grp;
        if (joint <= t_joint'(1)) begin
            grp = GRP_BASE;
        end else if (joint <= t_joint'(3)) begin
            grp = GRP_MID;
        end else begin
            grp = GRP_WRIST;
        end
        return grp;
    endfunction

    // True when the joint owns an entry of the state memory.
    function automatic logic jitl_joint_ok(input t_joint joint);
        return (32'(joint) < NUM_JOINTS);
    endfunction

endpackage

// File: hdl/jitl_if.sv
// Channel interfaces of the joint impedance torque limiter: sample input, command
// output and configuration write. Payload widths come from jitl_pkg.
interface jitl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [jitl_pkg::JOINT_W-1:0]   joint;
    logic signed [jitl_pkg::POS_W-1:0]     ref_pos;
    logic signed [jitl_pkg::POS_W-1:0]     cur_pos;
    logic signed [jitl_pkg::VEL_W-1:0]     target_vel;
    logic signed [jitl_pkg::VEL_W-1:0]     cur_vel;
    logic        [jitl_pkg::KP_W-1:0]      gain_pos;
    logic        [jitl_pkg::KD_W-1:0]      gain_vel;
    logic signed [jitl_pkg::FF_W-1:0]      torque_ff;

    modport source (
        output valid, joint, ref_pos, cur_pos, target_vel, cur_vel,
               gain_pos, gain_vel, torque_ff,
        input  ready
    );
    modport sink (
        input  valid, joint, ref_pos, cur_pos, target_vel, cur_vel,
               gain_pos, gain_vel, torque_ff,
        output ready
    );
endinterface

interface jitl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic        [jitl_pkg::JOINT_W-1:0]   joint_out;
    logic signed [jitl_pkg::TQ_W-1:0]      torque_out;
    logic                                  rate_limited;
    logic                                  magnitude_limited;

    modport source (
        output valid, joint_out, torque_out, rate_limited, magnitude_limited,
        input  ready
    );
    modport sink (
        input  valid, joint_out, torque_out, rate_limited, magnitude_limited,
        output ready
    );
endinterface

interface jitl_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [jitl_pkg::CFG_IDX_W-1:0]        index;
    logic [jitl_pkg::LIM_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/jitl_state_ram.sv
// Synchronous state memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero; same-cycle writes bypass.
module jitl_state_ram #(
    parameter int DEPTH = 7,
    parameter int WIDTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_vld [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array, written without reset.
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_waddr) < DEPTH)) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits, cleared at reset so every entry starts at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_we && (32'(i_waddr) < DEPTH)) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else if ((32'(i_raddr) < DEPTH) && r_vld[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/jitl_pd_calc.sv
// Two-stage PD impedance datapath: errors, gain products and the raw torque sum.
// Depends on jitl_pkg and the jitl_in_if channel.
module jitl_pd_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    jitl_in_if.sink             i_in,
    output logic                o_vld,
    input  logic                i_rdy,
    output jitl_pkg::t_raw_item o_item
);

    // First stage: position and velocity errors with the gains.
    logic                                r_s1_vld;
    jitl_pkg::t_joint                    r_s1_joint;
    logic signed [jitl_pkg::DPOS_W-1:0]  r_s1_dpos;
    logic signed [jitl_pkg::DVEL_W-1:0]  r_s1_dvel;
    logic        [jitl_pkg::KP_W-1:0]    r_s1_kp;
    logic        [jitl_pkg::KD_W-1:0]    r_s1_kd;
    logic signed [jitl_pkg::FF_W-1:0]    r_s1_ff;

    // Second stage: registered products.
    logic                                r_s2_vld;
    jitl_pkg::t_joint                    r_s2_joint;
    logic signed [jitl_pkg::PPOS_W-1:0]  r_s2_ppos;
    logic signed [jitl_pkg::PVEL_W-1:0]  r_s2_pvel;
    logic signed [jitl_pkg::FF_W-1:0]    r_s2_ff;

    logic s1_free;
    logic s2_free;
    logic s1_load;
    logic s2_load;
    logic signed [jitl_pkg::PPOS_W-1:0] ppos;
    logic signed [jitl_pkg::PVEL_W-1:0] pvel;

    // A stage takes a new item when it is empty or its item moves on.
    assign s2_free    = !r_s2_vld || i_rdy;
    assign s1_free    = !r_s1_vld || s2_free;
    assign s1_load    = i_in.valid && s1_free;
    assign s2_load    = r_s1_vld && s2_free;
    assign i_in.ready = s1_free;

    // Gain products, with the unsigned gains widened by a zero sign bit.
    assign ppos = jitl_pkg::PPOS_W'($signed({1'b0, r_s1_kp})) * jitl_pkg::PPOS_W'(r_s1_dpos);
    assign pvel = jitl_pkg::PVEL_W'($signed({1'b0, r_s1_kd})) * jitl_pkg::PVEL_W'(r_s1_dvel);

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_joint <= i_in.joint;
            r_s1_dpos  <= jitl_pkg::DPOS_W'(i_in.ref_pos) - jitl_pkg::DPOS_W'(i_in.cur_pos);
            r_s1_dvel  <= jitl_pkg::DVEL_W'(i_in.target_vel) - jitl_pkg::DVEL_W'(i_in.cur_vel);
            r_s1_kp    <= i_in.gain_pos;
            r_s1_kd    <= i_in.gain_vel;
            r_s1_ff    <= i_in.torque_ff;
        end
        if (s2_load) begin
            r_s2_joint <= r_s1_joint;
            r_s2_ppos  <= ppos;
            r_s2_pvel  <= pvel;
            r_s2_ff    <= r_s1_ff;
        end
    end

    // Raw torque: both products scaled down by arithmetic shifts, plus feed-forward.
    assign o_vld        = r_s2_vld;
    assign o_item.joint = r_s2_joint;
    assign o_item.raw   = jitl_pkg::RAW_W'(r_s2_ppos >>> jitl_pkg::POS_SHIFT)
                        + jitl_pkg::RAW_W'(r_s2_pvel >>> jitl_pkg::VEL_SHIFT)
                        + jitl_pkg::RAW_W'(r_s2_ff);

endmodule

// File: hdl/jitl_limit.sv
// Slew limiter and magnitude clamp applied to the raw torque of one item.
// Depends on jitl_pkg for widths and the result struct.
module jitl_limit (
    input  logic signed [jitl_pkg::RAW_W-1:0] i_raw,
    input  logic signed [jitl_pkg::TQ_W-1:0]  i_prev,
    input  logic        [jitl_pkg::LIM_W-1:0] i_step,
    input  logic        [jitl_pkg::LIM_W-1:0] i_lim,
    output jitl_pkg::t_lim_res                o_res
);

    logic signed [jitl_pkg::DIFF_W-1:0] prev_x;
    logic signed [jitl_pkg::DIFF_W-1:0] step_x;
    logic signed [jitl_pkg::DIFF_W-1:0] lim_x;
    logic signed [jitl_pkg::DIFF_W-1:0] delta;
    logic signed [jitl_pkg::DIFF_W-1:0] slewed;
    logic signed [jitl_pkg::DIFF_W-1:0] clamped;
    logic                               rate;
    logic                               mag;

    assign prev_x = jitl_pkg::DIFF_W'(i_prev);
    assign step_x = jitl_pkg::DIFF_W'($signed({1'b0, i_step}));
    assign lim_x  = jitl_pkg::DIFF_W'($signed({1'b0, i_lim}));
    assign delta  = jitl_pkg::DIFF_W'(i_raw) - prev_x;

    // Limit the change from the previous command to the step limit.
    always_comb begin
        slewed = jitl_pkg::DIFF_W'(i_raw);
        rate   = 1'b0;
        if (delta > step_x) begin
            slewed = prev_x + step_x;
            rate   = 1'b1;
        end else if (delta < -step_x) begin
            slewed = prev_x - step_x;
            rate   = 1'b1;
        end
    end

    // Clamp the magnitude; the clamp keeps the command within 16 bits.
    always_comb begin
        clamped = slewed;
        mag     = 1'b0;
        if (slewed > lim_x) begin
            clamped = lim_x;
            mag     = 1'b1;
        end else if (slewed < -lim_x) begin
            clamped = -lim_x;
            mag     = 1'b1;
        end
    end

    assign o_res.cmd  = jitl_pkg::TQ_W'(clamped);
    assign o_res.rate = rate;
    assign o_res.mag  = mag;

endmodule

// File: hdl/joint_impedance_torque_limiter_core.sv
// Joint impedance torque limiter.
// Input channel i_in: one joint sample per item (positions, velocities, gains,
// feed-forward). Output channel o_out: one torque command per item with the
// joint index and the rate and magnitude flags. Configuration channel i_cfg
// writes the six limit registers by index and is always ready; indexes above
// five are ignored.
// The block is a four-stage pipeline: error and gain capture, products, raw
// sum with the state memory read, then slew and clamp into the output
// register, which also writes the joint's new command back to memory. One item
// is taken every cycle while the receiver does not stall; a sample for the joint
// just ahead of it sees that command through the memory's write bypass.
// After reset every joint's previous command reads as zero (valid bits in the
// memory) and the limits hold their default values; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, items
// close up behind it in the empty stages, and input ready falls once all four
// stages are full.
module joint_impedance_torque_limiter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jitl_in_if.sink     i_in,
    jitl_out_if.source  o_out,
    jitl_cfg_if.sink    i_cfg
);

    // Limit registers, indexed by joint group.
    logic [jitl_pkg::LIM_W-1:0] r_step [jitl_pkg::NUM_GRPS];
    logic [jitl_pkg::LIM_W-1:0] r_abs  [jitl_pkg::NUM_GRPS];

    // Datapath to limiter stage handshake.
    logic                 pd_vld;
    logic                 pd_rdy;
    jitl_pkg::t_raw_item  pd_item;

    // Limiter stage.
    logic                             r_s3_vld;
    jitl_pkg::t_joint                 r_s3_joint;
    logic signed [jitl_pkg::RAW_W-1:0] r_s3_raw;
    logic                             s3_load;
    logic                             s3_go;
    logic                             out_free;
    logic                             s3_ok;
    jitl_pkg::t_grp                   s3_grp;
    logic [jitl_pkg::TQ_W-1:0]        ram_rdata;
    logic signed [jitl_pkg::TQ_W-1:0] prev;
    jitl_pkg::t_lim_res               lim_res;

    // Output register.
    logic                             r_out_vld;
    jitl_pkg::t_joint                 r_out_joint;
    logic signed [jitl_pkg::TQ_W-1:0] r_out_cmd;
    logic                             r_out_rate;
    logic                             r_out_mag;

    // Configuration writes; the channel never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step[jitl_pkg::GRP_BASE]  <= jitl_pkg::RST_STEP_BASE;
            r_step[jitl_pkg::GRP_MID]   <= jitl_pkg::RST_STEP_MID;
            r_step[jitl_pkg::GRP_WRIST] <= jitl_pkg::RST_STEP_WRIST;
            r_abs[jitl_pkg::GRP_BASE]   <= jitl_pkg::RST_ABS_BASE;
            r_abs[jitl_pkg::GRP_MID]    <= jitl_pkg::RST_ABS_MID;
            r_abs[jitl_pkg::GRP_WRIST]  <= jitl_pkg::RST_ABS_WRIST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jitl_pkg::REG_STEP_BASE:  r_step[jitl_pkg::GRP_BASE]  <= i_cfg.data;
                jitl_pkg::REG_STEP_MID:   r_step[jitl_pkg::GRP_MID]   <= i_cfg.data;
                jitl_pkg::REG_STEP_WRIST: r_step[jitl_pkg::GRP_WRIST] <= i_cfg.data;
                jitl_pkg::REG_ABS_BASE:   r_abs[jitl_pkg::GRP_BASE]   <= i_cfg.data;
                jitl_pkg::REG_ABS_MID:    r_abs[jitl_pkg::GRP_MID]    <= i_cfg.data;
                jitl_pkg::REG_ABS_WRIST:  r_abs[jitl_pkg::GRP_WRIST]  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // PD datapath: first two pipeline stages.
    jitl_pd_calc u_pd_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_vld   (pd_vld),
        .i_rdy   (pd_rdy),
        .o_item  (pd_item)
    );

    // Pipeline advance: the output register frees when empty or taken.
    assign out_free = !r_out_vld || o_out.ready;
    assign s3_go    = r_s3_vld && out_free;
    assign pd_rdy   = !r_s3_vld || s3_go;
    assign s3_load  = pd_vld && pd_rdy;

    // Previous-command memory: read as an item enters the limiter stage,
    // written as the item leaves it.
    jitl_state_ram #(
        .DEPTH (jitl_pkg::NUM_JOINTS),
        .WIDTH (jitl_pkg::TQ_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (s3_go && s3_ok),
        .i_waddr (jitl_pkg::MEM_AW'(r_s3_joint)),
        .i_wdata (lim_res.cmd),
        .i_re    (s3_load),
        .i_raddr (jitl_pkg::MEM_AW'(pd_item.joint)),
        .o_rdata (ram_rdata)
    );

    // Limiter stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (pd_rdy) begin
            r_s3_vld <= pd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_joint <= pd_item.joint;
            r_s3_raw   <= pd_item.raw;
        end
    end

    // A joint outside the memory starts from zero and uses the wrist limits.
    assign s3_ok  = jitl_pkg::jitl_joint_ok(r_s3_joint);
    assign s3_grp = jitl_pkg::jitl_group(r_s3_joint);
    assign prev   = s3_ok ? $signed(ram_rdata) : '0;

    jitl_limit u_limit (
        .i_raw  (r_s3_raw),
        .i_prev (prev),
        .i_step (r_step[s3_grp]),
        .i_lim  (r_abs[s3_grp]),
        .o_res  (lim_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_out_joint <= r_s3_joint;
            r_out_cmd   <= lim_res.cmd;
            r_out_rate  <= lim_res.rate;
            r_out_mag   <= lim_res.mag;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.joint_out         = r_out_joint;
    assign o_out.torque_out        = r_out_cmd;
    assign o_out.rate_limited      = r_out_rate;
    assign o_out.magnitude_limited = r_out_mag;

`ifndef SYNTHESIS
    // A delivered command never exceeds its group's magnitude clamp.
    a_cmd_in_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            ($signed(o_out.torque_out) <=
                 $signed({1'b0, r_abs[jitl_pkg::jitl_group(o_out.joint_out)]})) &&
            ($signed(o_out.torque_out) >=
                 -$signed({1'b0, r_abs[jitl_pkg::jitl_group(o_out.joint_out)]})))
        else $error("torque command outside the magnitude clamp");

    // A clamped command sits exactly on the clamp.
    a_mag_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.magnitude_limited |->
            ($signed(o_out.torque_out) ==
                 $signed({1'b0, r_abs[jitl_pkg::jitl_group(o_out.joint_out)]})) ||
            ($signed(o_out.torque_out) ==
                 -$signed({1'b0, r_abs[jitl_pkg::jitl_group(o_out.joint_out)]})))
        else $error("magnitude flag set but command not on the clamp");

    // An item held in the limiter stage keeps its contents while the output stalls.
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld && !out_free |=> r_s3_vld && $stable(r_s3_raw) && $stable(r_s3_joint))
        else $error("limiter stage item lost during stall");
`endif

endmodule
